/* rtl/core/hrcd_pkg.sv */
// ----------------------------------------------------------------------------
// hrcd_pkg
// Types, constants and helpers shared by the HTTP chunked response decoder.
// ----------------------------------------------------------------------------
package hrcd_pkg;

	localparam int CHUNK_LENGTH_BITS = 32;
	localparam int Q_DEPTH           = 4;
	localparam int Q_AW              = $clog2(Q_DEPTH);
	localparam int KW_LEN            = 7;

	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_LC_C  = 8'h63;

	localparam logic [9:0] STATUS_MAX = 10'd999;

	typedef enum logic [1:0] {
		ERR_NONE      = 2'd0,
		ERR_CHUNK_END = 2'd1,
		ERR_TRUNC     = 2'd2,
		ERR_OVERFLOW  = 2'd3
	} err_t;

	typedef enum logic [3:0] {
		PH_SL_PRE  = 4'd0,
		PH_SL_CODE = 4'd1,
		PH_HEADER  = 4'd2,
		PH_RAW     = 4'd3,
		PH_LEN     = 4'd4,
		PH_EXT     = 4'd5,
		PH_LEN_LF  = 4'd6,
		PH_DATA    = 4'd7,
		PH_END_CR  = 4'd8,
		PH_END_LF  = 4'd9,
		PH_DONE    = 4'd10,
		PH_ERR     = 4'd11
	} phase_t;

	typedef struct packed {
		logic [7:0] body_byte;
		logic       is_summary;
		logic [9:0] http_status;
		err_t       error_kind;
		logic       was_chunked;
	} result_t;

	// up to two results from one item, in order
	typedef struct packed {
		logic    push0;
		logic    push1;
		result_t res0;
		result_t res1;
	} push_t;

	function automatic logic [7:0] kw_char(input logic [2:0] pos);
		logic [7:0] c;
		case (pos)
			3'd0:    c = 8'h63; // c
			3'd1:    c = 8'h68; // h
			3'd2:    c = 8'h75; // u
			3'd3:    c = 8'h6E; // n
			3'd4:    c = 8'h6B; // k
			3'd5:    c = 8'h65; // e
			3'd6:    c = 8'h64; // d
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// {valid, value}
	function automatic logic [4:0] hex_decode(input logic [7:0] b);
		logic [4:0] r;
		if (b >= 8'h30 && b <= 8'h39) begin
			r = {1'b1, b[3:0]};
		end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
			r = {1'b1, b[3:0] + 4'd9};
		end else begin
			r = 5'd0;
		end
		return r;
	endfunction

endpackage

/* rtl/core/hrcd_in_if.sv */
// ----------------------------------------------------------------------------
// hrcd_in_if
// Raw response byte channel.
// ----------------------------------------------------------------------------
interface hrcd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_response;

	modport source (output valid, output data_byte, output end_of_response, input ready);
	modport sink   (input valid, input data_byte, input end_of_response, output ready);
endinterface

/* rtl/core/hrcd_out_if.sv */
// ----------------------------------------------------------------------------
// hrcd_out_if
// Decoded body byte / summary channel.
// ----------------------------------------------------------------------------
interface hrcd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] body_byte;
	logic       is_summary;
	logic [9:0] http_status;
	logic [1:0] error_kind;
	logic       was_chunked;

	modport source (output valid, output body_byte, output is_summary, output http_status,
		output error_kind, output was_chunked, input ready);
	modport sink   (input valid, input body_byte, input is_summary, input http_status,
		input error_kind, input was_chunked, output ready);
endinterface

/* rtl/core/hrcd_step.sv */
// ----------------------------------------------------------------------------
// hrcd_step
// Input register and parser state; one byte processed per cycle while the result queue has room.
// ----------------------------------------------------------------------------
module hrcd_step #(
	parameter int CHUNK_LENGTH_BITS = hrcd_pkg::CHUNK_LENGTH_BITS
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [7:0]      in_byte,
	input  logic            in_last,
	output logic            in_ready,
	input  logic            room,
	output hrcd_pkg::push_t push
);

	localparam int W = CHUNK_LENGTH_BITS;

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             last_s1;

	hrcd_pkg::phase_t phase_q, phase_n;
	logic [9:0]       acc_q, acc_n;
	logic [2:0]       mpos_q, mpos_n;
	logic             seen_q, seen_n;
	logic [1:0]       lend_q, lend_n;
	logic [W-1:0]     rem_q, rem_n;
	logic [3:0]       digits_q, digits_n;
	hrcd_pkg::err_t   err_q, err_n;

	logic             fire;
	logic             emit;
	logic             blank;
	logic [4:0]       hx;
	logic [13:0]      prod;
	logic [W-1:0]     rem_dec;
	hrcd_pkg::err_t   sum_err;
	hrcd_pkg::result_t body_r, sum_r;

	assign fire     = valid_s1 && room;
	assign in_ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
	end

	always_comb begin
		phase_n  = phase_q;
		acc_n    = acc_q;
		mpos_n   = mpos_q;
		seen_n   = seen_q;
		lend_n   = lend_q;
		rem_n    = rem_q;
		digits_n = digits_q;
		err_n    = err_q;
		emit     = 1'b0;
		blank    = 1'b0;
		hx       = hrcd_pkg::hex_decode(byte_s1);
		prod     = ({4'd0, acc_q} << 3) + ({4'd0, acc_q} << 1)
			+ {10'd0, byte_s1[3:0]};
		rem_dec  = rem_q - {{(W-1){1'b0}}, 1'b1};

		case (phase_q)
			hrcd_pkg::PH_SL_PRE, hrcd_pkg::PH_SL_CODE, hrcd_pkg::PH_HEADER: begin
				if (phase_q == hrcd_pkg::PH_SL_PRE) begin
					if (byte_s1 == hrcd_pkg::CH_SPACE) begin
						phase_n = hrcd_pkg::PH_SL_CODE;
					end else if (byte_s1 == hrcd_pkg::CH_CR) begin
						phase_n = hrcd_pkg::PH_HEADER;
					end
				end else if (phase_q == hrcd_pkg::PH_SL_CODE) begin
					if (byte_s1 >= hrcd_pkg::CH_ZERO && byte_s1 <= hrcd_pkg::CH_NINE) begin
						acc_n = (prod > {4'd0, hrcd_pkg::STATUS_MAX}) ?
							hrcd_pkg::STATUS_MAX : prod[9:0];
					end else begin
						phase_n = hrcd_pkg::PH_HEADER;
					end
				end
				// keyword search
				if (byte_s1 == hrcd_pkg::kw_char(mpos_q)) begin
					if (mpos_q == 3'(hrcd_pkg::KW_LEN - 1)) begin
						seen_n = 1'b1;
						mpos_n = 3'd0;
					end else begin
						mpos_n = mpos_q + 3'd1;
					end
				end else begin
					mpos_n = (byte_s1 == hrcd_pkg::CH_LC_C) ? 3'd1 : 3'd0;
				end
				// blank line search
				if (byte_s1 == hrcd_pkg::CH_CR) begin
					lend_n = (lend_q == 2'd2) ? 2'd3 : 2'd1;
				end else if (byte_s1 == hrcd_pkg::CH_LF) begin
					if (lend_q == 2'd3) begin
						lend_n = 2'd0;
						blank  = 1'b1;
					end else begin
						lend_n = (lend_q == 2'd1) ? 2'd2 : 2'd0;
					end
				end else begin
					lend_n = 2'd0;
				end
				if (blank) begin
					rem_n    = '0;
					digits_n = 4'd0;
					phase_n  = seen_n ? hrcd_pkg::PH_LEN : hrcd_pkg::PH_RAW;
				end
			end
			hrcd_pkg::PH_RAW: begin
				emit = 1'b1;
			end
			hrcd_pkg::PH_LEN: begin
				if (hx[4]) begin
					if (rem_q[W-1:W-4] != 4'd0) begin
						err_n   = hrcd_pkg::ERR_OVERFLOW;
						phase_n = hrcd_pkg::PH_ERR;
					end else begin
						rem_n = {rem_q[W-5:0], hx[3:0]};
						if (digits_q != 4'd15) begin
							digits_n = digits_q + 4'd1;
						end
					end
				end else if (byte_s1 == hrcd_pkg::CH_CR) begin
					phase_n = hrcd_pkg::PH_LEN_LF;
				end else begin
					phase_n = hrcd_pkg::PH_EXT;
				end
			end
			hrcd_pkg::PH_EXT: begin
				if (byte_s1 == hrcd_pkg::CH_CR) begin
					phase_n = hrcd_pkg::PH_LEN_LF;
				end
			end
			hrcd_pkg::PH_LEN_LF: begin
				if (byte_s1 == hrcd_pkg::CH_LF) begin
					if (rem_q == '0) begin
						phase_n = (digits_q != 4'd0) ? hrcd_pkg::PH_DONE : hrcd_pkg::PH_END_CR;
					end else begin
						phase_n = hrcd_pkg::PH_DATA;
					end
					digits_n = 4'd0;
				end else if (byte_s1 != hrcd_pkg::CH_CR) begin
					phase_n = hrcd_pkg::PH_EXT;
				end
			end
			hrcd_pkg::PH_DATA: begin
				emit  = 1'b1;
				rem_n = rem_dec;
				if (rem_dec == '0) begin
					phase_n = hrcd_pkg::PH_END_CR;
				end
			end
			hrcd_pkg::PH_END_CR: begin
				if (byte_s1 == hrcd_pkg::CH_CR) begin
					phase_n = hrcd_pkg::PH_END_LF;
				end else begin
					err_n   = hrcd_pkg::ERR_CHUNK_END;
					phase_n = hrcd_pkg::PH_ERR;
				end
			end
			hrcd_pkg::PH_END_LF: begin
				if (byte_s1 == hrcd_pkg::CH_LF) begin
					rem_n    = '0;
					digits_n = 4'd0;
					phase_n  = hrcd_pkg::PH_LEN;
				end else begin
					err_n   = hrcd_pkg::ERR_CHUNK_END;
					phase_n = hrcd_pkg::PH_ERR;
				end
			end
			default: begin
			end
		endcase

		sum_err = err_n;
		if (err_n == hrcd_pkg::ERR_NONE && phase_n != hrcd_pkg::PH_RAW
			&& phase_n != hrcd_pkg::PH_DONE) begin
			sum_err = hrcd_pkg::ERR_TRUNC;
		end

		body_r.body_byte   = byte_s1;
		body_r.is_summary  = 1'b0;
		body_r.http_status = 10'd0;
		body_r.error_kind  = hrcd_pkg::ERR_NONE;
		body_r.was_chunked = 1'b0;

		sum_r.body_byte   = 8'd0;
		sum_r.is_summary  = 1'b1;
		sum_r.http_status = acc_n;
		sum_r.error_kind  = sum_err;
		sum_r.was_chunked = seen_n;

		push.push0 = fire && (emit || last_s1);
		push.push1 = fire && emit && last_s1;
		push.res0  = emit ? body_r : sum_r;
		push.res1  = sum_r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= hrcd_pkg::PH_SL_PRE;
			acc_q    <= 10'd0;
			mpos_q   <= 3'd0;
			seen_q   <= 1'b0;
			lend_q   <= 2'd0;
			rem_q    <= '0;
			digits_q <= 4'd0;
			err_q    <= hrcd_pkg::ERR_NONE;
		end else if (fire) begin
			if (last_s1) begin
				phase_q  <= hrcd_pkg::PH_SL_PRE;
				acc_q    <= 10'd0;
				mpos_q   <= 3'd0;
				seen_q   <= 1'b0;
				lend_q   <= 2'd0;
				rem_q    <= '0;
				digits_q <= 4'd0;
				err_q    <= hrcd_pkg::ERR_NONE;
			end else begin
				phase_q  <= phase_n;
				acc_q    <= acc_n;
				mpos_q   <= mpos_n;
				seen_q   <= seen_n;
				lend_q   <= lend_n;
				rem_q    <= rem_n;
				digits_q <= digits_n;
				err_q    <= err_n;
			end
		end
	end

endmodule

/* rtl/core/hrcd_outq.sv */
// ----------------------------------------------------------------------------
// hrcd_outq
// Result queue: takes up to two results a cycle, gives one a cycle while the reader is ready.
// ----------------------------------------------------------------------------
module hrcd_outq (
	input  logic              clk,
	input  logic              arst_n,
	input  hrcd_pkg::push_t   push,
	output logic              room,
	output logic              out_valid,
	input  logic              out_ready,
	output hrcd_pkg::result_t out_res
);

	localparam int AW = hrcd_pkg::Q_AW;

	hrcd_pkg::result_t mem_q [hrcd_pkg::Q_DEPTH];
	logic [AW-1:0]     wp_q;
	logic [AW-1:0]     rp_q;
	logic [AW:0]       cnt_q;
	logic              pop;
	logic [AW:0]       n_push;

	assign room      = cnt_q <= (AW+1)'(hrcd_pkg::Q_DEPTH - 2);
	assign out_valid = cnt_q != '0;
	assign out_res   = mem_q[rp_q];
	assign pop       = out_valid && out_ready;
	assign n_push    = (AW+1)'(push.push0) + (AW+1)'(push.push1);

	always_ff @(posedge clk) begin
		if (push.push0) begin
			mem_q[wp_q] <= push.res0;
		end
		if (push.push1) begin
			mem_q[wp_q + AW'(1)] <= push.res1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + n_push[AW-1:0];
			rp_q  <= rp_q + AW'(pop);
			cnt_q <= cnt_q + n_push - (AW+1)'(pop);
		end
	end

endmodule

/* rtl/core/http_response_chunk_decoder.sv */
// ----------------------------------------------------------------------------
// http_response_chunk_decoder
// Status code, chunked transfer decoding and end-of-response summary.
// Path: a byte is held in the input register, and its results are written to
// the result queue, which offers them on the result channel.
// Throughput: one byte per cycle; the final byte of a response, when it is a
// body byte, gives two results, which leave the result queue at one per cycle;
// input stalls while the queue holds more than two results.
// Reset: arst_n clears parser state and empties the queue at once.
// ----------------------------------------------------------------------------
module http_response_chunk_decoder #(
	parameter int CHUNK_LENGTH_BITS = hrcd_pkg::CHUNK_LENGTH_BITS
) (
	input  logic  clk,
	input  logic  arst_n,
	hrcd_in_if.sink    stream,
	hrcd_out_if.source result
);

	hrcd_pkg::push_t   push;
	hrcd_pkg::result_t res;
	logic              room;

	hrcd_step #(
		.CHUNK_LENGTH_BITS(CHUNK_LENGTH_BITS)
	) u_step (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (stream.valid),
		.in_byte  (stream.data_byte),
		.in_last  (stream.end_of_response),
		.in_ready (stream.ready),
		.room     (room),
		.push     (push)
	);

	hrcd_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room      (room),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.out_res   (res)
	);

	assign result.body_byte   = res.body_byte;
	assign result.is_summary  = res.is_summary;
	assign result.http_status = res.http_status;
	assign result.error_kind  = res.error_kind;
	assign result.was_chunked = res.was_chunked;

endmodule
